// ----- rtl/dmq_pkg.sv -----
// ----------------------------------------------------------------------------
// dmq_pkg
// Shared types, constants and helpers for the delayed message queue.
// ----------------------------------------------------------------------------
package dmq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int REQ_W   = 3;
  localparam int ID_W    = 16;
  localparam int BODY_W  = 32;
  localparam int DELAY_W = 24;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 2;
  localparam int QCNT_W  = 5;

  // stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;

  // request codes
  localparam logic [REQ_W-1:0] REQ_POST   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POLL   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // one queue entry
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   id;
    logic [BODY_W-1:0] body;
  } entry_t;

  localparam entry_t ENTRY_NONE = '0;

  // per-cycle operation applied by every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP,
    CELL_CLEAR
  } cell_op_t;

  // command broadcast to the cell chain
  typedef struct packed {
    cell_op_t        op;
    entry_t          ins;
    logic [ID_W-1:0] key;
  } cell_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CANCEL
  } state_t;

  // a is later than b in wrapping time
  function automatic logic later_than(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

// ----- rtl/dmq_cell.sv -----
// ----------------------------------------------------------------------------
// dmq_cell
// One slot of the sorted queue; shifts with its neighbors on insert, remove and pop.
// ----------------------------------------------------------------------------
module dmq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dmq_pkg::cell_cmd_t cmd,
  input  dmq_pkg::entry_t   left_i,
  input  dmq_pkg::entry_t   right_i,
  input  logic              chain_i,
  output logic              chain_o,
  output dmq_pkg::entry_t   entry_o
);

  logic                           valid_r, valid_nxt;
  logic [dmq_pkg::TIME_W-1:0]     due_r;
  logic [dmq_pkg::ID_W-1:0]       id_r;
  logic [dmq_pkg::BODY_W-1:0]     body_r;
  logic                           cond;
  logic                           load;
  dmq_pkg::entry_t                nxt;

  assign entry_o = '{valid: valid_r, due: due_r, id: id_r, body: body_r};

  // local condition that starts the shifting region
  always_comb begin
    case (cmd.op)
      dmq_pkg::CELL_INSERT:
        cond = !valid_r || dmq_pkg::later_than(due_r, cmd.ins.due);
      dmq_pkg::CELL_REMOVE:
        cond = valid_r && (id_r == cmd.key);
      default:
        cond = 1'b0;
    endcase
  end

  assign chain_o = chain_i | cond;

  // next content of the slot
  always_comb begin
    nxt  = entry_o;
    load = 1'b0;
    case (cmd.op)
      dmq_pkg::CELL_INSERT: begin
        if (chain_i) begin
          nxt  = left_i;
          load = 1'b1;
        end else if (cond) begin
          nxt  = cmd.ins;
          load = 1'b1;
        end
      end
      dmq_pkg::CELL_REMOVE: begin
        if (chain_o) begin
          nxt  = right_i;
          load = 1'b1;
        end
      end
      dmq_pkg::CELL_POP: begin
        nxt  = right_i;
        load = 1'b1;
      end
      dmq_pkg::CELL_CLEAR: begin
        nxt  = dmq_pkg::ENTRY_NONE;
        load = 1'b1;
      end
      default: begin
        nxt  = entry_o;
        load = 1'b0;
      end
    endcase
    valid_nxt = nxt.valid;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      due_r  <= nxt.due;
      id_r   <= nxt.id;
      body_r <= nxt.body;
    end
  end

endmodule

// ----- rtl/delayed_message_queue_top.sv -----
// ----------------------------------------------------------------------------
// delayed_message_queue_top
// Deadline-ordered message queue with a millisecond clock.
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH cells kept sorted by due time; an item is
// taken in the idle state and executed in the execute state that follows. A
// cancel on an empty or stopped queue is answered there as invalid; any other
// cancel moves on to the cancel state, where the cell chain removes one match
// per cycle by shifting the tail left, and a last step confirms no match
// remains. A new item is taken while a result still waits in the output
// register; execution waits only when that register is still full.
// ----------------------------------------------------------------------------
module delayed_message_queue_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // req_type[2:0], message_id[18:3], message_body[50:19], delay_ms[74:51]
  input  logic [dmq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], delivered[2], out_id[18:3], out_body[50:19],
  // queue_count[55:51]
  output logic [dmq_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int D = dmq_pkg::QUEUE_DEPTH;

  dmq_pkg::state_t               state_r, state_nxt;
  logic [dmq_pkg::REQ_W-1:0]     req_r;
  logic [dmq_pkg::ID_W-1:0]      id_r;
  logic [dmq_pkg::BODY_W-1:0]    body_r;
  logic [dmq_pkg::TIME_W-1:0]    due_r;
  logic [dmq_pkg::TIME_W-1:0]    clock_r, clock_nxt;
  logic [dmq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          stopping_r, stopping_nxt;
  logic                          out_valid_r;
  logic [dmq_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                          accept;
  logic                          slot_free;
  logic                          emit;
  logic [dmq_pkg::STAT_W-1:0]    res_status;
  logic                          res_got;
  logic [dmq_pkg::ID_W-1:0]      res_id;
  logic [dmq_pkg::BODY_W-1:0]    res_body;
  logic                          head_due;
  logic                          any_match;

  dmq_pkg::cell_cmd_t            cmd;
  dmq_pkg::entry_t               entries [D];
  dmq_pkg::entry_t               left_in [D];
  dmq_pkg::entry_t               right_in [D];
  logic [D:0]                    chain;
  logic [D-1:0]                  valid_vec;

  assign in_tready  = (state_r == dmq_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // cell chain
  assign chain[0] = 1'b0;
  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_in[gi] = dmq_pkg::ENTRY_NONE;
      end else begin : g_mid_l
        assign left_in[gi] = entries[gi-1];
      end
      if (gi == D - 1) begin : g_last
        assign right_in[gi] = dmq_pkg::ENTRY_NONE;
      end else begin : g_mid_r
        assign right_in[gi] = entries[gi+1];
      end
      assign valid_vec[gi] = entries[gi].valid;

      dmq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .left_i  (left_in[gi]),
        .right_i (right_in[gi]),
        .chain_i (chain[gi]),
        .chain_o (chain[gi+1]),
        .entry_o (entries[gi])
      );
    end
  endgenerate

  assign any_match = chain[D];
  assign head_due  = entries[0].valid && !dmq_pkg::later_than(entries[0].due, clock_r);

  // request register, due time added at intake
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_tdata[2:0];
      id_r   <= in_tdata[18:3];
      body_r <= in_tdata[50:19];
      due_r  <= clock_r + dmq_pkg::TIME_W'(in_tdata[74:51]);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dmq_pkg::ST_IDLE;
      clock_r    <= '0;
      count_r    <= '0;
      stopping_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clock_r    <= clock_nxt;
      count_r    <= count_nxt;
      stopping_r <= stopping_nxt;
    end
  end

  // request execution
  always_comb begin
    state_nxt    = state_r;
    clock_nxt    = clock_r;
    count_nxt    = count_r;
    stopping_nxt = stopping_r;
    emit         = 1'b0;
    res_status   = dmq_pkg::STAT_OK;
    res_got      = 1'b0;
    res_id       = '0;
    res_body     = '0;
    cmd.op       = dmq_pkg::CELL_HOLD;
    cmd.ins      = '{valid: 1'b1, due: due_r, id: id_r, body: body_r};
    cmd.key      = id_r;
    case (state_r)
      dmq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dmq_pkg::ST_EXEC;
        end
      end
      dmq_pkg::ST_EXEC: begin
        if (req_r == dmq_pkg::REQ_CANCEL) begin
          if (stopping_r || count_r == '0) begin
            if (slot_free) begin
              emit       = 1'b1;
              res_status = dmq_pkg::STAT_INVALID;
              state_nxt  = dmq_pkg::ST_IDLE;
            end
          end else begin
            state_nxt = dmq_pkg::ST_CANCEL;
          end
        end else if (slot_free) begin
          emit      = 1'b1;
          state_nxt = dmq_pkg::ST_IDLE;
          case (req_r)
            dmq_pkg::REQ_POST: begin
              if (stopping_r) begin
                res_status = dmq_pkg::STAT_INVALID;
              end else if (count_r == dmq_pkg::CNT_W'(D)) begin
                res_status = dmq_pkg::STAT_FULL;
              end else begin
                cmd.op    = dmq_pkg::CELL_INSERT;
                count_nxt = count_r + dmq_pkg::CNT_W'(1);
              end
            end
            dmq_pkg::REQ_TICK: begin
              clock_nxt = clock_r + dmq_pkg::TIME_W'(1);
            end
            dmq_pkg::REQ_POLL: begin
              if (stopping_r) begin
                res_status = dmq_pkg::STAT_INVALID;
              end else if (head_due) begin
                res_got   = 1'b1;
                res_id    = entries[0].id;
                res_body  = entries[0].body;
                cmd.op    = dmq_pkg::CELL_POP;
                count_nxt = count_r - dmq_pkg::CNT_W'(1);
              end
            end
            dmq_pkg::REQ_STOP: begin
              stopping_nxt = 1'b1;
              cmd.op       = dmq_pkg::CELL_CLEAR;
              count_nxt    = '0;
            end
            default: begin
              res_status = dmq_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      dmq_pkg::ST_CANCEL: begin
        // one matching entry leaves per cycle
        cmd.op = dmq_pkg::CELL_REMOVE;
        if (any_match) begin
          count_nxt = count_r - dmq_pkg::CNT_W'(1);
        end else if (slot_free) begin
          emit      = 1'b1;
          state_nxt = dmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmq_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {dmq_pkg::QCNT_W'(count_nxt), res_body, res_id, res_got, res_status};
    end
  end

  // held entries form a prefix matching the count
  assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == int'(count_r)) && ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("cell valid bits do not match the entry count");

  // count never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dmq_pkg::CNT_W'(D))
    else $error("entry count above queue depth");

  // a stopped queue stays empty
  assert property (@(posedge clk) disable iff (!rst_n)
    stopping_r |-> (count_r == '0))
    else $error("entries held while stopped");

  // a result is never written over one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result overwrites a pending result");

  // a cancel step with a match leaves exactly one entry fewer
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmq_pkg::ST_CANCEL && any_match) |=> (count_r == $past(count_r) - 1'b1))
    else $error("cancel step did not remove one entry");

endmodule
